>>> rtl/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg
// shared types and constants of the stereo block matcher
// ----------------------------------------------------------------------------
package sbm_pkg;

   localparam int PIX_W     = 8;
   localparam int IMG_W_W   = 11;
   localparam int IMG_H_W   = 12;
   localparam int LIM_W     = 6;
   localparam int THR_W     = 16;
   localparam int DISP_W    = 6;
   localparam int MAPCOL_W  = 10;
   localparam int ROW_W     = 12;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;

   localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH     = 11'd640;
   localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT    = 12'd480;
   localparam logic [LIM_W-1:0]   RST_DISPARITY_LIMIT = 6'd50;
   localparam logic [THR_W-1:0]   RST_ERROR_THRESHOLD = 16'd1000;

   localparam logic [1:0] CSR_IMAGE_WIDTH     = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT    = 2'd1;
   localparam logic [1:0] CSR_DISPARITY_LIMIT = 2'd2;
   localparam logic [1:0] CSR_ERROR_THRESHOLD = 2'd3;

   typedef struct packed {
      logic write;
      logic issue;
      logic first;
      logic last;
      logic load;
   } sbm_cmd_type;

   typedef struct packed {
      logic win_valid;
      logic out_free;
   } sbm_status_type;

endpackage

>>> rtl/sbm_ram.sv
// ----------------------------------------------------------------------------
// sbm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sbm_ctrl.sv
// ----------------------------------------------------------------------------
// sbm_ctrl
// sequencer: takes a request, walks disparities and window columns
// ----------------------------------------------------------------------------
module sbm_ctrl #(
   parameter int WIN_SIZE   = 9,
   parameter int DISP_RANGE = 64,
   localparam int XW = (WIN_SIZE > 1) ? $clog2(WIN_SIZE) : 1,
   localparam int DW = (DISP_RANGE > 1) ? $clog2(DISP_RANGE) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sbm_pkg::sbm_status_type status,
   input  logic [DW-1:0]          max_disp,
   output sbm_pkg::sbm_cmd_type   cmd,
   output logic [XW-1:0]          col_step,
   output logic [DW-1:0]          disp_step
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_DRAIN,
      S_OUTPUT
   } state_type;

   localparam logic [1:0] DRAIN_LAST = 2'd2;

   state_type      state_ff, state_in;
   logic [XW-1:0]  x_ff, x_in;
   logic [DW-1:0]  d_ff, d_in;
   logic [1:0]     drain_ff, drain_in;

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      d_in     = d_ff;
      drain_in = drain_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            x_in = '0;
            d_in = '0;
            state_in = status.win_valid ? S_SCAN : S_IDLE;
         end
         S_SCAN: begin
            if (x_ff == XW'(WIN_SIZE - 1)) begin
               x_in = '0;
               if (d_ff == max_disp) begin
                  drain_in = '0;
                  state_in = S_DRAIN;
               end else begin
                  d_in = d_ff + 1'b1;
               end
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (drain_ff == DRAIN_LAST) begin
               state_in = S_OUTPUT;
            end else begin
               drain_in = drain_ff + 1'b1;
            end
         end
         S_OUTPUT: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         x_ff     <= '0;
         d_ff     <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         x_ff     <= x_in;
         d_ff     <= d_in;
         drain_ff <= drain_in;
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign cmd.write  = (state_ff == S_IDLE) && req_valid;
   assign cmd.issue  = (state_ff == S_SCAN);
   assign cmd.first  = (x_ff == '0);
   assign cmd.last   = (x_ff == XW'(WIN_SIZE - 1));
   assign cmd.load   = (state_ff == S_OUTPUT) && status.out_free;
   assign col_step   = x_ff;
   assign disp_step  = d_ff;

endmodule

>>> rtl/sbm_datapath.sv
// ----------------------------------------------------------------------------
// sbm_datapath
// line stores, position tracking, squared difference pipeline, best match
// ----------------------------------------------------------------------------
module sbm_datapath #(
   parameter int WIN_SIZE   = 9,
   parameter int MAX_WIDTH  = 1024,
   parameter int DISP_RANGE = 64,
   localparam int XW = (WIN_SIZE > 1) ? $clog2(WIN_SIZE) : 1,
   localparam int DW = (DISP_RANGE > 1) ? $clog2(DISP_RANGE) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [sbm_pkg::IMG_W_W-1:0]      cfg_width,
   input  logic [sbm_pkg::IMG_H_W-1:0]      cfg_height,
   input  logic [sbm_pkg::LIM_W-1:0]        cfg_limit,
   input  logic [sbm_pkg::THR_W-1:0]        cfg_threshold,
   input  logic                             in_frame_start,
   input  logic [sbm_pkg::PIX_W-1:0]        in_left,
   input  logic [sbm_pkg::PIX_W-1:0]        in_right,
   input  sbm_pkg::sbm_cmd_type             cmd,
   input  logic [XW-1:0]                    col_step,
   input  logic [DW-1:0]                    disp_step,
   output sbm_pkg::sbm_status_type          status,
   output logic [DW-1:0]                    max_disp,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [sbm_pkg::DISP_W-1:0]       out_disparity,
   output logic [sbm_pkg::MAPCOL_W-1:0]     out_column,
   output logic [sbm_pkg::ROW_W-1:0]        out_row,
   output logic                             out_last
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WC_W  = COL_W + 1;
   localparam int RW    = sbm_pkg::ROW_W;
   localparam int SQ_W  = 2 * sbm_pkg::PIX_W;
   localparam int CS_W  = SQ_W + $clog2(WIN_SIZE + 1);
   localparam int SSE_W = SQ_W + $clog2(WIN_SIZE * WIN_SIZE + 1);
   localparam int HALF  = (WIN_SIZE - 1) / 2;
   localparam int AREA  = WIN_SIZE * WIN_SIZE;

   typedef struct packed {
      logic          valid;
      logic          first;
      logic          last;
      logic [DW-1:0] disp;
   } tag_type;

   // position
   logic [COL_W-1:0] col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [XW-1:0]    slot_ff, slot_in;
   logic [31:0]      w_eff, h_eff, c0, r0, c1, r1, lim32, c_win;
   logic [XW-1:0]    s0;
   logic [XW-1:0]    cur_slot;
   logic [COL_W-1:0] cur_col;
   logic             win_hit;

   // window info
   logic                       win_valid_ff, win_valid_in;
   logic [COL_W-1:0]           c_ff, c_in;
   logic [sbm_pkg::MAPCOL_W-1:0] map_col_ff, map_col_in;
   logic [RW-1:0]              map_row_ff, map_row_in;
   logic                       last_ff, last_in;
   logic [DW-1:0]              maxd_ff, maxd_in;
   logic [SSE_W-1:0]           allowed_ff, allowed_in;

   // pipeline
   logic [sbm_pkg::PIX_W-1:0] l_q [WIN_SIZE];
   logic [sbm_pkg::PIX_W-1:0] r_q [WIN_SIZE];
   logic [COL_W-1:0]          l_addr, r_addr;
   tag_type                   p1_ff, p1_in, p2_ff, p3_ff;
   logic [SQ_W-1:0]           sq_ff [WIN_SIZE];
   logic [SQ_W-1:0]           sq_in [WIN_SIZE];
   logic [CS_W-1:0]           cs_ff, cs_in;
   logic [SSE_W-1:0]          acc_ff, acc_in, best_ff, best_in, total;
   logic [DW-1:0]             bestd_ff, bestd_in;

   // output register
   logic                          ovalid_ff, ovalid_in;
   logic [sbm_pkg::DISP_W-1:0]    odisp_ff, odisp_in;
   logic [sbm_pkg::MAPCOL_W-1:0]  ocol_ff, ocol_in;
   logic [RW-1:0]                 orow_ff, orow_in;
   logic                          olast_ff, olast_in;

   always_comb begin
      if (cfg_width == '0) begin
         w_eff = 32'd1;
      end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
         w_eff = 32'(MAX_WIDTH);
      end else begin
         w_eff = 32'(cfg_width);
      end
      h_eff = (cfg_height == '0) ? 32'd1 : 32'(cfg_height);

      c0 = in_frame_start ? 32'd0 : 32'(col_ff);
      r0 = in_frame_start ? 32'd0 : 32'(row_ff);
      s0 = in_frame_start ? '0 : slot_ff;
      if (c0 >= w_eff) begin
         c0 = 32'd0;
         r0 = r0 + 32'd1;
         s0 = (s0 == XW'(WIN_SIZE - 1)) ? '0 : s0 + 1'b1;
      end
      if (r0 >= h_eff) begin
         r0 = 32'd0;
         s0 = '0;
      end
      cur_col  = COL_W'(c0);
      cur_slot = s0;

      c1 = c0 + 32'd1;
      r1 = r0 + 32'd1;
      if (c1 >= w_eff) begin
         col_in = '0;
         if (r1 >= h_eff) begin
            row_in  = '0;
            slot_in = '0;
         end else begin
            row_in  = RW'(r1);
            slot_in = (s0 == XW'(WIN_SIZE - 1)) ? '0 : s0 + 1'b1;
         end
      end else begin
         col_in  = COL_W'(c1);
         row_in  = RW'(r0);
         slot_in = s0;
      end

      win_hit = (c0 >= 32'(WIN_SIZE - 1)) && (r0 >= 32'(WIN_SIZE - 1)) &&
                (c1 < w_eff) && (r1 < h_eff);
      c_win = c0 - 32'(WIN_SIZE - 1);
      lim32 = 32'(cfg_limit);
      if (lim32 > c_win) begin
         lim32 = c_win;
      end
      if (lim32 > 32'(DISP_RANGE - 1)) begin
         lim32 = 32'(DISP_RANGE - 1);
      end
   end

   always_comb begin
      win_valid_in = win_valid_ff;
      c_in         = c_ff;
      map_col_in   = map_col_ff;
      map_row_in   = map_row_ff;
      last_in      = last_ff;
      maxd_in      = maxd_ff;
      allowed_in   = allowed_ff;
      if (cmd.write) begin
         win_valid_in = win_hit;
         c_in         = COL_W'(c_win);
         map_col_in   = sbm_pkg::MAPCOL_W'(c_win + 32'(HALF));
         map_row_in   = RW'(r0 - 32'(WIN_SIZE - 1) + 32'(HALF));
         last_in      = (r1 + 32'd1 == h_eff) && (c1 + 32'd1 == w_eff);
         maxd_in      = DW'(lim32);
         allowed_in   = SSE_W'(cfg_threshold) * SSE_W'(AREA);
      end
   end

   assign l_addr = COL_W'(c_ff + COL_W'(col_step));
   assign r_addr = COL_W'(c_ff + COL_W'(col_step) - COL_W'(disp_step));

   for (genvar i = 0; i < WIN_SIZE; i++) begin : g_line
      logic wr_en;
      assign wr_en = cmd.write && (cur_slot == XW'(i));
      sbm_ram #(.WIDTH(sbm_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_left (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (cur_col),
         .wr_data (in_left),
         .rd_addr (l_addr),
         .rd_data (l_q[i])
      );
      sbm_ram #(.WIDTH(sbm_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_right (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (cur_col),
         .wr_data (in_right),
         .rd_addr (r_addr),
         .rd_data (r_q[i])
      );
   end

   always_comb begin
      logic signed [sbm_pkg::PIX_W:0]       df;
      logic signed [2*sbm_pkg::PIX_W+1:0]   pr;
      p1_in.valid = cmd.issue;
      p1_in.first = cmd.first;
      p1_in.last  = cmd.last;
      p1_in.disp  = disp_step;
      cs_in = '0;
      for (int i = 0; i < WIN_SIZE; i++) begin
         df = $signed({1'b0, l_q[i]}) - $signed({1'b0, r_q[i]});
         pr = df * df;
         sq_in[i] = pr[SQ_W-1:0];
         cs_in = cs_in + CS_W'(sq_ff[i]);
      end
   end

   always_comb begin
      total    = (p3_ff.first ? '0 : acc_ff) + SSE_W'(cs_ff);
      acc_in   = acc_ff;
      best_in  = best_ff;
      bestd_in = bestd_ff;
      if (p3_ff.valid) begin
         acc_in = total;
         if (p3_ff.last && ((p3_ff.disp == '0) || (total < best_ff))) begin
            best_in  = total;
            bestd_in = p3_ff.disp;
         end
      end
   end

   always_comb begin
      ovalid_in = ovalid_ff;
      odisp_in  = odisp_ff;
      ocol_in   = ocol_ff;
      orow_in   = orow_ff;
      olast_in  = olast_ff;
      if (cmd.load) begin
         ovalid_in = 1'b1;
         odisp_in  = (best_ff < allowed_ff) ? sbm_pkg::DISP_W'(bestd_ff) : '0;
         ocol_in   = map_col_ff;
         orow_in   = map_row_ff;
         olast_in  = last_ff;
      end else if (out_ready) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         slot_ff      <= '0;
         win_valid_ff <= 1'b0;
         p1_ff        <= '0;
         p2_ff        <= '0;
         p3_ff        <= '0;
         ovalid_ff    <= 1'b0;
      end else begin
         if (cmd.write) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            slot_ff <= slot_in;
         end
         win_valid_ff <= win_valid_in;
         p1_ff        <= p1_in;
         p2_ff        <= p1_ff;
         p3_ff        <= p2_ff;
         ovalid_ff    <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff       <= c_in;
      map_col_ff <= map_col_in;
      map_row_ff <= map_row_in;
      last_ff    <= last_in;
      maxd_ff    <= maxd_in;
      allowed_ff <= allowed_in;
      sq_ff      <= sq_in;
      cs_ff      <= cs_in;
      acc_ff     <= acc_in;
      best_ff    <= best_in;
      bestd_ff   <= bestd_in;
      odisp_ff   <= odisp_in;
      ocol_ff    <= ocol_in;
      orow_ff    <= orow_in;
      olast_ff   <= olast_in;
   end

   assign status.win_valid = win_valid_ff;
   assign status.out_free  = !ovalid_ff || out_ready;
   assign max_disp         = maxd_ff;
   assign out_valid        = ovalid_ff;
   assign out_disparity    = odisp_ff;
   assign out_column       = ocol_ff;
   assign out_row          = orow_ff;
   assign out_last         = olast_ff;

endmodule

>>> rtl/stereo_block_match_ssd.sv
// ----------------------------------------------------------------------------
// stereo_block_match_ssd
// stereo block matcher, sum of squared differences, winner take all
// ----------------------------------------------------------------------------
// requests on req_ carry one left/right gray pixel pair in raster order,
// req_tuser marks the first pair of a frame. each request is written into
// one of WIN_SIZE line stores per image. when it completes a window, one
// result leaves on rsp_: best disparity, window centre column and row, and
// rsp_tlast on the last window of the frame.
// csr_ is an apb port with image width, height, disparity limit and error
// threshold; write it only while the block is idle.
// a request that completes no window returns to idle without a search;
// else disparities 0 to maxd are searched, where maxd is the number of
// disparities searched minus one; one window column per cycle goes through
// the shared squared difference unit. the result is loaded into the output
// register once the search pipeline has drained.
// one request is worked on at a time; a finished result sits in the output
// register while the next request is taken, and a stalled rsp_tready holds
// the result and only delays the completion of the following window.
// reset clears position, pipeline and output valid; the line stores are
// not cleared and every entry is written before it is read.
module stereo_block_match_ssd #(
   parameter int WIN_SIZE   = 9,
   parameter int MAX_WIDTH  = 1024,
   parameter int DISP_RANGE = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [15:0]                  req_tdata,   // left_pixel, right_pixel
   input  logic                         req_tuser,   // frame_start
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [31:0]                  rsp_tdata,   // disparity, map_column, map_row
   output logic                         rsp_tlast,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [sbm_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [sbm_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [sbm_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);

   localparam int XW = (WIN_SIZE > 1) ? $clog2(WIN_SIZE) : 1;
   localparam int DW = (DISP_RANGE > 1) ? $clog2(DISP_RANGE) : 1;

   logic [sbm_pkg::IMG_W_W-1:0] width_ff;
   logic [sbm_pkg::IMG_H_W-1:0] height_ff;
   logic [sbm_pkg::LIM_W-1:0]   limit_ff;
   logic [sbm_pkg::THR_W-1:0]   thr_ff;
   logic                        csr_wr;
   logic [1:0]                  csr_idx;

   sbm_pkg::sbm_cmd_type    cmd;
   sbm_pkg::sbm_status_type status;
   logic [XW-1:0]           col_step;
   logic [DW-1:0]           disp_step;
   logic [DW-1:0]           max_disp;
   logic [sbm_pkg::DISP_W-1:0]   out_disp;
   logic [sbm_pkg::MAPCOL_W-1:0] out_col;
   logic [sbm_pkg::ROW_W-1:0]    out_row;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sbm_pkg::RST_IMAGE_WIDTH;
         height_ff <= sbm_pkg::RST_IMAGE_HEIGHT;
         limit_ff  <= sbm_pkg::RST_DISPARITY_LIMIT;
         thr_ff    <= sbm_pkg::RST_ERROR_THRESHOLD;
      end else if (csr_wr) begin
         case (csr_idx)
            sbm_pkg::CSR_IMAGE_WIDTH:     width_ff  <= csr_pwdata[sbm_pkg::IMG_W_W-1:0];
            sbm_pkg::CSR_IMAGE_HEIGHT:    height_ff <= csr_pwdata[sbm_pkg::IMG_H_W-1:0];
            sbm_pkg::CSR_DISPARITY_LIMIT: limit_ff  <= csr_pwdata[sbm_pkg::LIM_W-1:0];
            sbm_pkg::CSR_ERROR_THRESHOLD: thr_ff    <= csr_pwdata[sbm_pkg::THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         sbm_pkg::CSR_IMAGE_WIDTH:     csr_prdata = sbm_pkg::CSR_DW'(width_ff);
         sbm_pkg::CSR_IMAGE_HEIGHT:    csr_prdata = sbm_pkg::CSR_DW'(height_ff);
         sbm_pkg::CSR_DISPARITY_LIMIT: csr_prdata = sbm_pkg::CSR_DW'(limit_ff);
         sbm_pkg::CSR_ERROR_THRESHOLD: csr_prdata = sbm_pkg::CSR_DW'(thr_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   sbm_ctrl #(.WIN_SIZE(WIN_SIZE), .DISP_RANGE(DISP_RANGE)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .max_disp  (max_disp),
      .cmd       (cmd),
      .col_step  (col_step),
      .disp_step (disp_step)
   );

   sbm_datapath #(
      .WIN_SIZE   (WIN_SIZE),
      .MAX_WIDTH  (MAX_WIDTH),
      .DISP_RANGE (DISP_RANGE)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg_width      (width_ff),
      .cfg_height     (height_ff),
      .cfg_limit      (limit_ff),
      .cfg_threshold  (thr_ff),
      .in_frame_start (req_tuser),
      .in_left        (req_tdata[7:0]),
      .in_right       (req_tdata[15:8]),
      .cmd            (cmd),
      .col_step       (col_step),
      .disp_step      (disp_step),
      .status         (status),
      .max_disp       (max_disp),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_disparity  (out_disp),
      .out_column     (out_col),
      .out_row        (out_row),
      .out_last       (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, out_row, out_col, out_disp};

endmodule

>>> rtl/sbm_checker.sv
// ----------------------------------------------------------------------------
// sbm_checker
// port level checks of the stereo block matcher
// ----------------------------------------------------------------------------
module sbm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // one request at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // no result right after reset
   a_rst_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result after reset");

   // a new result never appears in the cycle after a request is taken
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result without search");

endmodule

bind stereo_block_match_ssd sbm_checker u_sbm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
